### hw/rtl/idw_depth_window_interpolator_assert.svh
// ---------------------------------------------------------------------------
// IDW interpolator assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef IDW_DEPTH_WINDOW_INTERPOLATOR_ASSERT_SVH
`define IDW_DEPTH_WINDOW_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define IDW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idw assertion failed");

// next-cycle implication
`define IDW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idw assertion failed");

`endif

### hw/rtl/idw_pkg.sv
// ---------------------------------------------------------------------------
// IDW interpolator package
// Shared constants, codes and request structs.
// ---------------------------------------------------------------------------
package idw_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_RADIUS     = 7;
    localparam int STORE_ROWS     = 2 * MAX_RADIUS + 1;
    localparam int WEIGHT_ENTRIES = 128;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WIDTH_W = COL_W + 1;
    localparam int ROW_W   = 13;
    localparam int CY_W    = 12;
    localparam int SLOT_W  = 4;
    localparam int RAD_W   = 3;
    localparam int WIDX_W  = $clog2(WEIGHT_ENTRIES);
    localparam int CI_W    = 4;

    localparam int PROD_W  = 65;
    localparam int ACC_W   = 73;
    localparam int DEN_W   = 40;
    localparam int GROUPS  = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b1;

    localparam logic MODE_DEPTH  = 1'b0;
    localparam logic MODE_WEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [RAD_W-1:0]   RADIUS_RESET = 3'd2;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic               is_wt;
        logic [WIDX_W-1:0]  widx;
        logic [31:0]        wval;
        logic [31:0]        depth;
        logic               dvalid;
        logic [COL_W-1:0]   col;
        logic [SLOT_W-1:0]  slot;
        logic [ROW_W-1:0]   row;
        logic               emit;
        logic [COL_W-1:0]   lo;
        logic [COL_W-1:0]   hi;
        logic [CY_W-1:0]    cy;
        logic [WIDTH_W-1:0] w;
        logic [RAD_W-1:0]   r;
    } t_job;

    typedef struct packed {
        logic             first;
        logic             lastc;
        logic             lastres;
        logic [COL_W-1:0] cx;
        logic [CY_W-1:0]  cy;
    } t_tag;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [DEN_W-1:0] den;
        logic [COL_W-1:0] cx;
        logic [CY_W-1:0]  cy;
        logic             last;
    } t_fin;

endpackage

### hw/rtl/idw_if.sv
// ---------------------------------------------------------------------------
// IDW interpolator channel interfaces
// Input request, result and configuration write channels.
// ---------------------------------------------------------------------------
interface idw_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [31:0]                 depth;
    logic                               depth_valid;
    logic                               frame_start;
    logic [idw_pkg::WIDX_W-1:0]         weight_index;
    logic [31:0]                        weight_value;

    modport source (output valid, mode, depth, depth_valid, frame_start,
                    weight_index, weight_value, input ready);
    modport sink (input valid, mode, depth, depth_valid, frame_start,
                  weight_index, weight_value, output ready);
endinterface

interface idw_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [31:0]             out_depth;
    logic                           out_valid;
    logic [idw_pkg::COL_W-1:0]      center_x;
    logic [idw_pkg::CY_W-1:0]       center_y;
    logic                           last;

    modport source (output valid, out_depth, out_valid, center_x, center_y, last,
                    input ready);
    modport sink (input valid, out_depth, out_valid, center_x, center_y, last,
                  output ready);
endinterface

interface idw_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [idw_pkg::CFG_IDX_W-1:0]      index;
    logic [idw_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/idw_front.sv
// ---------------------------------------------------------------------------
// IDW front end
// Config registers, raster position tracking, request classification and
// the job queue toward the window engine.
// ---------------------------------------------------------------------------
module idw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    idw_in_if.sink        i_in,
    idw_cfg_if.sink       i_cfg,
    input  logic          i_job_pop,
    output logic          o_job_valid,
    output idw_pkg::t_job o_job
);

    logic [idw_pkg::WIDTH_W-1:0] r_width;
    logic [idw_pkg::RAD_W-1:0]   r_radius;
    logic [idw_pkg::COL_W-1:0]   r_col;
    logic [idw_pkg::ROW_W-1:0]   r_row;
    logic [idw_pkg::SLOT_W-1:0]  r_slot;

    idw_pkg::t_job               r_queue [idw_pkg::QUEUE_DEPTH];
    logic [idw_pkg::QPTR_W-1:0]  r_wp;
    logic [idw_pkg::QPTR_W-1:0]  r_rp;
    logic [idw_pkg::QCNT_W-1:0]  r_cnt;

    logic                        push;
    logic [idw_pkg::WIDTH_W-1:0] w_eff;
    logic [idw_pkg::COL_W-1:0]   col_in;
    logic [idw_pkg::COL_W-1:0]   col;
    logic [idw_pkg::ROW_W-1:0]   row;
    logic [idw_pkg::SLOT_W-1:0]  slot;
    logic                        last_col;
    logic [idw_pkg::COL_W-1:0]   rad_c;
    idw_pkg::t_job               n_job;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_cnt != idw_pkg::QCNT_W'(idw_pkg::QUEUE_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_queue[r_rp];

    always_comb begin
        col_in = i_in.frame_start ? '0 : r_col;
        row    = i_in.frame_start ? '0 : r_row;
        slot   = i_in.frame_start ? '0 : r_slot;
        if (r_width == '0) begin
            w_eff = idw_pkg::WIDTH_W'(1);
        end else if (r_width > idw_pkg::WIDTH_W'(idw_pkg::MAX_WIDTH)) begin
            w_eff = idw_pkg::WIDTH_W'(idw_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        // a column past a shrunk width counts as the last column
        if ({1'b0, col_in} >= w_eff) begin
            col = idw_pkg::COL_W'(w_eff - 1'b1);
        end else begin
            col = col_in;
        end
        last_col = ({1'b0, col} == w_eff - 1'b1);
        rad_c    = idw_pkg::COL_W'(r_radius);

        n_job        = '0;
        n_job.is_wt  = (i_in.mode == idw_pkg::MODE_WEIGHT);
        n_job.widx   = i_in.weight_index;
        n_job.wval   = i_in.weight_value;
        n_job.depth  = i_in.depth;
        n_job.dvalid = i_in.depth_valid;
        n_job.col    = col;
        n_job.slot   = slot;
        n_job.row    = row;
        n_job.w      = w_eff;
        n_job.r      = r_radius;
        n_job.cy     = idw_pkg::CY_W'(row - idw_pkg::ROW_W'(r_radius));
        if (last_col) begin
            n_job.lo = (col >= rad_c) ? col - rad_c : '0;
            n_job.hi = idw_pkg::COL_W'(w_eff - 1'b1);
        end else begin
            n_job.lo = col - rad_c;
            n_job.hi = col - rad_c;
        end
        n_job.emit = (row >= idw_pkg::ROW_W'(r_radius)) && (last_col || (col >= rad_c));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= idw_pkg::WIDTH_RESET;
            r_radius <= idw_pkg::RADIUS_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    idw_pkg::CFG_WIDTH:  r_width  <= i_cfg.data;
                    idw_pkg::CFG_RADIUS: r_radius <= i_cfg.data[idw_pkg::RAD_W-1:0];
                    default: ;
                endcase
            end
            if (push) begin
                r_wp <= r_wp + 1'b1;
                if (!n_job.is_wt) begin
                    if (last_col) begin
                        r_col <= '0;
                        r_row <= row + 1'b1;
                        // row counter wrap starts over at ring slot 0
                        if (row == '1 || slot == idw_pkg::SLOT_W'(idw_pkg::STORE_ROWS - 1)) begin
                            r_slot <= '0;
                        end else begin
                            r_slot <= slot + 1'b1;
                        end
                    end else begin
                        r_col <= col + 1'b1;
                        r_row <= row;
                        r_slot <= slot;
                    end
                end
            end
            if (i_job_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({push, i_job_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wp] <= n_job;
        end
    end

endmodule

### hw/rtl/idw_back.sv
// ---------------------------------------------------------------------------
// IDW window engine
// Line store and weight banks, one window column per cycle while not held by
// the divider, product tree and window accumulation.
// ---------------------------------------------------------------------------
module idw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  idw_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_fin_valid,
    output idw_pkg::t_fin o_fin,
    input  logic          i_fin_take
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                        r_state;
    logic [idw_pkg::COL_W-1:0]   r_cx;
    logic [idw_pkg::COL_W-1:0]   r_hi;
    logic [idw_pkg::CY_W-1:0]    r_cy;
    logic [idw_pkg::WIDTH_W-1:0] r_w;
    logic [idw_pkg::RAD_W-1:0]   r_r;
    logic [idw_pkg::SLOT_W-1:0]  r_slot;
    logic [idw_pkg::ROW_W-1:0]   r_row;
    logic [idw_pkg::CI_W-1:0]    r_ci;

    logic                        en;
    logic                        pop;
    logic                        issue;
    logic                        ci_end;
    logic signed [idw_pkg::COL_W+1:0] rx;
    logic                        col_ok;
    logic [idw_pkg::COL_W-1:0]   rx_addr;
    logic [idw_pkg::RAD_W-1:0]   ia;
    logic [5:0]                  isq;
    logic [idw_pkg::SLOT_W-1:0]  lane_d  [idw_pkg::STORE_ROWS];
    logic [idw_pkg::RAD_W-1:0]   lane_ja [idw_pkg::STORE_ROWS];
    logic [idw_pkg::WIDX_W-1:0]  lane_d2 [idw_pkg::STORE_ROWS];
    logic [idw_pkg::STORE_ROWS-1:0] lane_mask;
    idw_pkg::t_tag               tag;

    logic [32:0]                 rd_z  [idw_pkg::STORE_ROWS];
    logic [31:0]                 rd_wt [idw_pkg::STORE_ROWS];

    logic                        r_s1_v;
    logic [idw_pkg::STORE_ROWS-1:0] r_s1_mask;
    idw_pkg::t_tag               r_s1_tag;

    logic signed [idw_pkg::PROD_W-1:0] prod [idw_pkg::STORE_ROWS];
    logic [31:0]                 wsel [idw_pkg::STORE_ROWS];
    logic                        r_s2_v;
    logic signed [idw_pkg::PROD_W-1:0] r_s2_prod [idw_pkg::STORE_ROWS];
    logic [31:0]                 r_s2_wt [idw_pkg::STORE_ROWS];
    idw_pkg::t_tag               r_s2_tag;

    logic signed [idw_pkg::ACC_W-1:0] gsum [idw_pkg::GROUPS];
    logic [idw_pkg::DEN_W-1:0]   gden [idw_pkg::GROUPS];
    logic                        r_s3_v;
    logic signed [idw_pkg::ACC_W-1:0] r_s3_acc [idw_pkg::GROUPS];
    logic [idw_pkg::DEN_W-1:0]   r_s3_den [idw_pkg::GROUPS];
    idw_pkg::t_tag               r_s3_tag;

    logic signed [idw_pkg::ACC_W-1:0] r_acc;
    logic [idw_pkg::DEN_W-1:0]   r_den;
    logic signed [idw_pkg::ACC_W-1:0] n_acc;
    logic [idw_pkg::DEN_W-1:0]   n_den;
    logic                        r_fin_v;
    idw_pkg::t_fin               r_fin;

    // whole engine holds while a finished window waits for the divider
    assign en          = !r_fin_v || i_fin_take;
    assign pop         = en && (r_state == S_IDLE) && i_job_valid;
    assign o_job_pop   = pop;
    assign issue       = en && (r_state == S_RUN);
    assign ci_end      = (r_ci == {r_r, 1'b0});
    assign o_fin_valid = r_fin_v;
    assign o_fin       = r_fin;

    always_comb begin
        rx = $signed({2'b00, r_cx}) - $signed({9'd0, r_r}) + $signed({8'd0, r_ci});
        col_ok  = !rx[idw_pkg::COL_W+1] && (rx < $signed({1'b0, r_w}));
        rx_addr = rx[idw_pkg::COL_W-1:0];
        ia  = (r_ci >= {1'b0, r_r}) ? idw_pkg::RAD_W'(r_ci - {1'b0, r_r})
                                    : idw_pkg::RAD_W'({1'b0, r_r} - r_ci);
        isq = {3'd0, ia} * {3'd0, ia};
        for (int b = 0; b < idw_pkg::STORE_ROWS; b++) begin
            // ring distance of bank b behind the newest row
            if (r_slot >= idw_pkg::SLOT_W'(b)) begin
                lane_d[b] = r_slot - idw_pkg::SLOT_W'(b);
            end else begin
                lane_d[b] = idw_pkg::SLOT_W'(5'(r_slot) + 5'(idw_pkg::STORE_ROWS) - 5'(b));
            end
            lane_ja[b] = (lane_d[b] >= {1'b0, r_r}) ? idw_pkg::RAD_W'(lane_d[b] - {1'b0, r_r})
                                                   : idw_pkg::RAD_W'({1'b0, r_r} - lane_d[b]);
            lane_d2[b] = idw_pkg::WIDX_W'({1'b0, isq})
                       + idw_pkg::WIDX_W'({4'd0, lane_ja[b]} * {4'd0, lane_ja[b]});
            lane_mask[b] = col_ok && (lane_d[b] <= {r_r, 1'b0})
                        && (r_row >= idw_pkg::ROW_W'(lane_d[b]));
        end
        tag.first   = (r_ci == '0);
        tag.lastc   = ci_end;
        tag.lastres = (r_cx == r_hi);
        tag.cx      = r_cx;
        tag.cy      = r_cy;
    end

    for (genvar b = 0; b < idw_pkg::STORE_ROWS; b++) begin : g_lane
        logic [32:0] r_line [idw_pkg::MAX_WIDTH];
        logic [31:0] r_wtab [idw_pkg::WEIGHT_ENTRIES];
        logic [32:0] r_rd_z;
        logic [31:0] r_rd_wt;

        always_ff @(posedge i_clk) begin
            if (pop && !i_job.is_wt && (i_job.slot == idw_pkg::SLOT_W'(b))) begin
                r_line[i_job.col] <= {i_job.dvalid, i_job.depth};
            end
            if (en) begin
                r_rd_z <= r_line[rx_addr];
            end
        end

        always_ff @(posedge i_clk) begin
            if (pop && i_job.is_wt) begin
                r_wtab[i_job.widx] <= i_job.wval;
            end
            if (en) begin
                r_rd_wt <= r_wtab[lane_d2[b]];
            end
        end

        assign rd_z[b]  = r_rd_z;
        assign rd_wt[b] = r_rd_wt;
    end

    always_comb begin
        for (int b = 0; b < idw_pkg::STORE_ROWS; b++) begin
            if (r_s1_mask[b] && rd_z[b][32]) begin
                prod[b] = $signed(rd_z[b][31:0]) * $signed({1'b0, rd_wt[b]});
                wsel[b] = rd_wt[b];
            end else begin
                prod[b] = '0;
                wsel[b] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < idw_pkg::GROUPS; g++) begin
            gsum[g] = '0;
            gden[g] = '0;
            for (int k = 0; k < 4; k++) begin
                if (4 * g + k < idw_pkg::STORE_ROWS) begin
                    gsum[g] = gsum[g] + r_s2_prod[4 * g + k];
                    gden[g] = gden[g] + idw_pkg::DEN_W'(r_s2_wt[4 * g + k]);
                end
            end
        end
    end

    always_comb begin
        if (r_s3_tag.first) begin
            n_acc = '0;
            n_den = '0;
        end else begin
            n_acc = r_acc;
            n_den = r_den;
        end
        n_acc = n_acc + r_s3_acc[0] + r_s3_acc[1] + r_s3_acc[2] + r_s3_acc[3];
        n_den = n_den + r_s3_den[0] + r_s3_den[1] + r_s3_den[2] + r_s3_den[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ci    <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_fin_v <= 1'b0;
        end else begin
            if (i_fin_take) begin
                r_fin_v <= 1'b0;
            end
            if (en) begin
                r_s1_v <= issue;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
                if (r_s3_v && r_s3_tag.lastc) begin
                    r_fin_v <= 1'b1;
                end
                unique case (r_state)
                    S_IDLE: begin
                        if (pop && !i_job.is_wt && i_job.emit) begin
                            r_ci    <= '0;
                            r_state <= S_RUN;
                        end
                    end
                    S_RUN: begin
                        if (ci_end) begin
                            r_ci <= '0;
                            if (r_cx == r_hi) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cx   <= i_job.lo;
            r_hi   <= i_job.hi;
            r_cy   <= i_job.cy;
            r_w    <= i_job.w;
            r_r    <= i_job.r;
            r_slot <= i_job.slot;
            r_row  <= i_job.row;
        end else if (issue && ci_end) begin
            r_cx <= r_cx + 1'b1;
        end
        if (en) begin
            r_s1_mask <= lane_mask;
            r_s1_tag  <= tag;
            r_s2_prod <= prod;
            r_s2_wt   <= wsel;
            r_s2_tag  <= r_s1_tag;
            r_s3_acc  <= gsum;
            r_s3_den  <= gden;
            r_s3_tag  <= r_s2_tag;
            if (r_s3_v) begin
                r_acc <= n_acc;
                r_den <= n_den;
                if (r_s3_tag.lastc) begin
                    r_fin.acc  <= n_acc;
                    r_fin.den  <= n_den;
                    r_fin.cx   <= r_s3_tag.cx;
                    r_fin.cy   <= r_s3_tag.cy;
                    r_fin.last <= r_s3_tag.lastres;
                end
            end
        end
    end

endmodule

### hw/rtl/idw_div.sv
// ---------------------------------------------------------------------------
// IDW divider and result register
// Radix-4 restoring divide of |sum(w*z)| by sum(w), rounding, saturation.
// ---------------------------------------------------------------------------
`include "idw_depth_window_interpolator_assert.svh"

module idw_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fin_valid,
    input  idw_pkg::t_fin i_fin,
    output logic          o_fin_take,
    idw_out_if.source     o_out
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RND  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  r_state;
    logic [idw_pkg::DEN_W:0]     r_rem;
    logic [31:0]                 r_q;
    logic [3:0]                  r_cnt;
    logic [idw_pkg::DEN_W-1:0]   r_den;
    logic                        r_neg;
    logic [idw_pkg::COL_W-1:0]   r_cx;
    logic [idw_pkg::CY_W-1:0]    r_cy;
    logic                        r_last;
    logic [31:0]                 r_res;
    logic                        r_res_ok;

    logic                        r_out_v;
    logic [31:0]                 r_out_depth;
    logic                        r_out_ok;
    logic [idw_pkg::COL_W-1:0]   r_out_cx;
    logic [idw_pkg::CY_W-1:0]    r_out_cy;
    logic                        r_out_last;

    logic [idw_pkg::ACC_W-1:0]   mag;
    logic [idw_pkg::DEN_W:0]     t;
    logic [idw_pkg::DEN_W:0]     n_rem;
    logic [31:0]                 n_q;
    logic                        rup;
    logic [32:0]                 q33;
    logic [31:0]                 n_res;
    logic                        out_free;

    assign o_fin_take = (r_state == S_IDLE) && i_fin_valid;
    assign out_free   = !r_out_v || o_out.ready;

    assign o_out.valid     = r_out_v;
    assign o_out.out_depth = r_out_depth;
    assign o_out.out_valid = r_out_ok;
    assign o_out.center_x  = r_out_cx;
    assign o_out.center_y  = r_out_cy;
    assign o_out.last      = r_out_last;

    always_comb begin
        mag = i_fin.acc[idw_pkg::ACC_W-1] ? (~i_fin.acc + 1'b1) : i_fin.acc;
        n_rem = r_rem;
        n_q   = r_q;
        t     = '0;
        // two quotient bits per cycle
        for (int k = 0; k < 2; k++) begin
            t   = {n_rem[idw_pkg::DEN_W-1:0], n_q[31]};
            n_q = {n_q[30:0], 1'b0};
            if (t >= {1'b0, r_den}) begin
                n_rem  = t - {1'b0, r_den};
                n_q[0] = 1'b1;
            end else begin
                n_rem = t;
            end
        end
        // round half away from zero on the magnitude
        rup = (r_rem >= ({1'b0, r_den} - r_rem));
        q33 = {1'b0, r_q} + 33'(rup);
        if (r_neg) begin
            n_res = (q33 >= 33'h0_8000_0000) ? idw_pkg::SAT_NEG : 32'(33'd0 - q33);
        end else begin
            n_res = (q33 > 33'h0_7FFF_FFFF) ? idw_pkg::SAT_POS : q33[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_fin_valid) begin
                        r_cnt <= '0;
                        if (i_fin.den == '0) begin
                            r_state <= S_DONE;
                        end else if (mag[idw_pkg::ACC_W-1:32] >= {1'b0, i_fin.den}) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_fin_valid) begin
                    r_den  <= i_fin.den;
                    r_neg  <= i_fin.acc[idw_pkg::ACC_W-1];
                    r_cx   <= i_fin.cx;
                    r_cy   <= i_fin.cy;
                    r_last <= i_fin.last;
                    r_rem  <= mag[idw_pkg::ACC_W-1:32];
                    r_q    <= mag[31:0];
                    if (i_fin.den == '0) begin
                        r_res    <= '0;
                        r_res_ok <= 1'b0;
                    end else begin
                        // quotient of at least 2^32 saturates either way
                        r_res    <= i_fin.acc[idw_pkg::ACC_W-1] ? idw_pkg::SAT_NEG
                                                                : idw_pkg::SAT_POS;
                        r_res_ok <= 1'b1;
                    end
                end
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_q   <= n_q;
            end
            S_RND: r_res <= n_res;
            S_DONE: begin
                if (out_free) begin
                    r_out_depth <= r_res;
                    r_out_ok    <= r_res_ok;
                    r_out_cx    <= r_cx;
                    r_out_cy    <= r_cy;
                    r_out_last  <= r_last;
                end
            end
            default: ;
        endcase
    end

    `IDW_ASSERT_IMP(a_div_den_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_den != '0)
    `IDW_ASSERT_IMP(a_div_rem_below, i_clk, i_rst_n, r_state == S_DIV, r_rem < {1'b0, r_den})
    `IDW_ASSERT_IMP(a_empty_is_zero, i_clk, i_rst_n, r_out_v && !r_out_ok, r_out_depth == '0)
    `IDW_ASSERT_NXT(a_div_flow, i_clk, i_rst_n, r_state == S_DIV, r_state == S_DIV || r_state == S_RND)

endmodule

### hw/rtl/idw_depth_window_interpolator.sv
// ---------------------------------------------------------------------------
// IDW depth window interpolator
// Streaming inverse-distance-weighted fill of a Q16.16 depth raster.
// ---------------------------------------------------------------------------
// Depth requests (mode 0) arrive in raster order; each is written to a ring
// of 15 line banks and, once radius rows are in, releases the window center
// radius rows up and radius columns left (the whole tail of the row on its
// last column). Weight requests (mode 1) load a 128-entry Q8.24 table
// indexed by squared distance; they take effect in request order. The front
// end takes one request per cycle into a 4-deep job queue while it has room.
// The window engine reads one window column of all 15 banks per cycle
// unless held by the divider, so a center issues 2R+1 columns through the
// bank read, product, group sum and accumulate registers; each finished
// sum then goes through a radix-4 divider of 16 iterations plus round and
// handoff, overlapped with the next window; the engine holds while a finished
// window waits for the divider. Empty windows report out_valid 0 and depth
// 0. Close a frame with R rows of invalid padding. Configuration writes are
// taken at any time but must only be issued while the block is idle.
// ---------------------------------------------------------------------------
module idw_depth_window_interpolator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idw_in_if.sink     i_in,
    idw_cfg_if.sink    i_cfg,
    idw_out_if.source  o_out
);

    logic          job_valid;
    idw_pkg::t_job job;
    logic          job_pop;
    logic          fin_valid;
    idw_pkg::t_fin fin;
    logic          fin_take;

    // request classification, position tracking, job queue
    idw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_job_pop   (job_pop),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    // line store, weight banks, per-window weighted sums
    idw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_fin_valid (fin_valid),
        .o_fin       (fin),
        .i_fin_take  (fin_take)
    );

    // quotient, rounding, saturation, result register
    idw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fin_valid (fin_valid),
        .i_fin       (fin),
        .o_fin_take  (fin_take),
        .o_out       (o_out)
    );

endmodule
